@@ sv/truth_match_delta_r_unit_assert.svh @@
// Assertion macros for the truth match delta-R unit.
// Included by the top level; compiled away when SYNTH is defined.
`ifndef TRUTH_MATCH_DELTA_R_UNIT_ASSERT_SVH
`define TRUTH_MATCH_DELTA_R_UNIT_ASSERT_SVH

`ifndef SYNTH
`define TMDR_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TMDR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TMDR_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define TMDR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ sv/tmdr_pkg.sv @@
// Shared types, constants and lookup functions of the truth match delta-R unit.
// Used by tmdr_iso_corr and truth_match_delta_r_unit; depends on nothing.
package tmdr_pkg;

    localparam int ETA_W      = 14;
    localparam int PHI_W      = 13;
    localparam int PT_W       = 16;
    localparam int ID_W       = 24;
    localparam int ISO_W      = 16;
    localparam int RHO_W      = 12;
    localparam int BIN_W      = 3;
    localparam int DR_W       = 24;
    localparam int FRAC_W     = 8;
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int S_TDATA_W  = 168;
    localparam int M_TDATA_W  = 96;
    localparam int ISO_CH     = 3;
    localparam int EA_W       = 9;
    localparam int X_W        = 21;
    localparam int PROD_W     = 42;
    localparam int RECIP_SH   = 30;
    localparam int Q_W        = PROD_W - RECIP_SH;
    localparam int SQ_W       = 28;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_QUERY  = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        CLS_OTHER    = 2'd0,
        CLS_PHOTON   = 2'd1,
        CLS_ELECTRON = 2'd2
    } cls_t;

    typedef struct packed {
        cls_t                     cls;
        logic [PT_W-1:0]          pt;
        logic signed [PHI_W-1:0]  phi;
        logic signed [ETA_W-1:0]  eta;
    } entry_t;

    localparam logic [CFG_IDX_W-1:0] CFG_DR_MAX_SQ    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DPT_MAX_FRAC = 2'd1;

    localparam logic [DR_W-1:0]   DR_MAX_SQ_RST    = 24'd41943;
    localparam logic [FRAC_W-1:0] DPT_MAX_FRAC_RST = 8'd51;

    localparam logic signed [14:0] PI_FX     = 15'sd3217;
    localparam logic signed [14:0] NEG_PI_FX = -15'sd3217;
    localparam logic signed [14:0] TWO_PI_FX = 15'sd6434;

    localparam logic signed [ID_W-1:0] PHOTON_ID    = 24'sd22;
    localparam logic signed [ID_W-1:0] NEG_PHOTON_ID = -24'sd22;
    localparam logic signed [ID_W-1:0] ELECTRON_ID  = 24'sd11;
    localparam logic signed [ID_W-1:0] POSITRON_ID  = -24'sd11;
    localparam logic signed [ID_W-1:0] Z_ID         = 24'sd23;

    localparam logic [1:0] CH_CHARGED = 2'd0;
    localparam logic [1:0] CH_PHOTON  = 2'd1;
    localparam logic [1:0] CH_NEUTRAL = 2'd2;

    // Reciprocal of 1000 scaled by 2^30, rounded up; exact for the 21-bit range used.
    localparam logic [X_W-1:0] RECIP_M   = 21'd1073742;
    localparam logic [X_W-1:0] DIV_ROUND = 21'd999;

    localparam logic [ETA_W-1:0] EDGE_0 = 14'd1024;
    localparam logic [ETA_W-1:0] EDGE_1 = 14'd1515;
    localparam logic [ETA_W-1:0] EDGE_2 = 14'd2048;
    localparam logic [ETA_W-1:0] EDGE_3 = 14'd2253;
    localparam logic [ETA_W-1:0] EDGE_4 = 14'd2356;
    localparam logic [ETA_W-1:0] EDGE_5 = 14'd2458;

    function automatic logic [BIN_W-1:0] area_bin(input logic [ETA_W-1:0] abs_eta);
        logic [BIN_W-1:0] b;
        if (abs_eta < EDGE_0) begin
            b = 3'd0;
        end else if (abs_eta < EDGE_1) begin
            b = 3'd1;
        end else if (abs_eta < EDGE_2) begin
            b = 3'd2;
        end else if (abs_eta < EDGE_3) begin
            b = 3'd3;
        end else if (abs_eta < EDGE_4) begin
            b = 3'd4;
        end else if (abs_eta < EDGE_5) begin
            b = 3'd5;
        end else begin
            b = 3'd6;
        end
        return b;
    endfunction

    // Effective areas in units of 0.001.
    function automatic logic [EA_W-1:0] eff_area(input logic [1:0] ch,
                                                 input logic [BIN_W-1:0] bin);
        logic [EA_W-1:0] a;
        a = '0;
        case (ch)
            CH_CHARGED: begin
                case (bin)
                    3'd0: a = 9'd12;
                    3'd1: a = 9'd10;
                    3'd2: a = 9'd14;
                    3'd3: a = 9'd12;
                    3'd4: a = 9'd16;
                    3'd5: a = 9'd20;
                    default: a = 9'd12;
                endcase
            end
            CH_PHOTON: begin
                case (bin)
                    3'd0: a = 9'd148;
                    3'd1: a = 9'd130;
                    3'd2: a = 9'd112;
                    3'd3: a = 9'd216;
                    3'd4: a = 9'd262;
                    3'd5: a = 9'd260;
                    default: a = 9'd266;
                endcase
            end
            default: begin
                case (bin)
                    3'd0: a = 9'd30;
                    3'd1: a = 9'd57;
                    3'd2: a = 9'd39;
                    3'd3: a = 9'd15;
                    3'd4: a = 9'd24;
                    3'd5: a = 9'd39;
                    default: a = 9'd72;
                endcase
            end
        endcase
        return a;
    endfunction

endpackage

@@ sv/tmdr_iso_corr.sv @@
// Pileup correction of the three isolation sums: iso - ceil(area * rho / 1000),
// clamped at zero. Two register stages; depends on tmdr_pkg.
module tmdr_iso_corr (
    input  logic                                         aclk,
    input  logic [tmdr_pkg::BIN_W-1:0]                   bin,
    input  logic [tmdr_pkg::RHO_W-1:0]                   rho,
    input  logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::ISO_W-1:0] iso,
    output logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::ISO_W-1:0] corr
);

    logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::X_W-1:0]    x_reg;
    logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::PROD_W-1:0] prod_reg;
    logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::Q_W-1:0]    quot;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < tmdr_pkg::ISO_CH; i++) begin
            x_reg[i]    <= tmdr_pkg::X_W'(tmdr_pkg::eff_area(2'(i), bin)) *
                           tmdr_pkg::X_W'(rho);
            prod_reg[i] <= tmdr_pkg::PROD_W'(x_reg[i] + tmdr_pkg::DIV_ROUND) *
                           tmdr_pkg::PROD_W'(tmdr_pkg::RECIP_M);
        end
    end

    always_comb begin
        for (int i = 0; i < tmdr_pkg::ISO_CH; i++) begin
            quot[i] = prod_reg[i][tmdr_pkg::PROD_W-1:tmdr_pkg::RECIP_SH];
            if (iso[i] > tmdr_pkg::ISO_W'(quot[i])) begin
                corr[i] = iso[i] - tmdr_pkg::ISO_W'(quot[i]);
            end else begin
                corr[i] = '0;
            end
        end
    end

endmodule

@@ sv/truth_match_delta_r_unit.sv @@
// Clear and append words are handled in the idle state. A query word passes through
// the prep, scan and finish states; its result word depends on N, the stored entries,
// through the scan that reads the truth memory one entry per cycle; the next word
// is taken the cycle after the result is registered. Reset clears the entry count,
// the state machine and the output valid and loads the register defaults.
// Depends on tmdr_pkg, tmdr_iso_corr and truth_match_delta_r_unit_assert.svh.
`include "truth_match_delta_r_unit_assert.svh"

module truth_match_delta_r_unit #(
    parameter int TRUTH_DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tmdr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmdr_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // eta, phi, pt, particle_id, parent_id, cluster_eta, charged_iso,
    // photon_iso, neutral_iso, energy_density, zero fill
    input  logic [tmdr_pkg::S_TDATA_W-1:0]      s_tdata,
    // opcode
    input  logic [tmdr_pkg::OP_W-1:0]           s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // photon_match, electron_match, match_pt, match_eta, match_phi, area_bin,
    // charged_iso_corr, photon_iso_corr, neutral_iso_corr
    output logic [tmdr_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int AW = (TRUTH_DEPTH > 1) ? $clog2(TRUTH_DEPTH) : 1;
    localparam int CW = $clog2(TRUTH_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TRUTH_DEPTH);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREP   = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                         state_reg, state_next;
    logic [CW-1:0]                  cnt_reg, cnt_next;
    logic [CW-1:0]                  iss_reg, iss_next;
    logic                           prep_reg, prep_next;
    logic                           rd_vld_reg, st2_vld_reg;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [tmdr_pkg::DR_W-1:0]      dr_max_reg, dr_max_next;
    logic [tmdr_pkg::FRAC_W-1:0]    frac_reg, frac_next;
    logic [tmdr_pkg::M_TDATA_W-1:0] m_tdata_reg;

    tmdr_pkg::opcode_t                    in_op;
    logic signed [tmdr_pkg::ETA_W-1:0]    in_eta, in_ceta;
    logic signed [tmdr_pkg::PHI_W-1:0]    in_phi;
    logic [tmdr_pkg::PT_W-1:0]            in_pt;
    logic signed [tmdr_pkg::ID_W-1:0]     in_pid, in_mid;
    logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::ISO_W-1:0] in_iso;
    logic [tmdr_pkg::RHO_W-1:0]           in_rho;
    logic [tmdr_pkg::ETA_W-1:0]           in_abs_ceta;

    logic accept, issue, load_out, mem_we;
    tmdr_pkg::cls_t   in_cls;
    tmdr_pkg::entry_t wr_entry;

    tmdr_pkg::entry_t mem [TRUTH_DEPTH];
    tmdr_pkg::entry_t mem_rdata_reg;

    logic signed [tmdr_pkg::ETA_W-1:0]    q_eta_reg;
    logic signed [tmdr_pkg::PHI_W-1:0]    q_phi_reg;
    logic [tmdr_pkg::PT_W-1:0]            q_pt_reg;
    logic [tmdr_pkg::BIN_W-1:0]           q_bin_reg;
    logic [tmdr_pkg::RHO_W-1:0]           q_rho_reg;
    logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::ISO_W-1:0] q_iso_reg;
    logic [tmdr_pkg::ISO_CH-1:0][tmdr_pkg::ISO_W-1:0] iso_corr;

    logic signed [14:0]           de, dp_raw, dp_hi, dp;
    logic signed [29:0]           de_prod, dp_prod;
    logic [tmdr_pkg::PT_W-1:0]    pt_diff;
    logic [tmdr_pkg::SQ_W-1:0]    de_sq_reg, dp_sq_reg;
    logic [tmdr_pkg::PT_W-1:0]    diff_reg;
    logic [23:0]                  fracpt_reg;
    tmdr_pkg::entry_t             t_reg;
    logic [tmdr_pkg::SQ_W:0]      dr2;
    logic                         hit;

    logic                              pm_reg, em_reg;
    logic [tmdr_pkg::PT_W-1:0]         mpt_reg;
    logic signed [tmdr_pkg::ETA_W-1:0] meta_reg;
    logic signed [tmdr_pkg::PHI_W-1:0] mphi_reg;

    assign in_op     = tmdr_pkg::opcode_t'(s_tuser);
    assign in_eta    = s_tdata[13:0];
    assign in_phi    = s_tdata[26:14];
    assign in_pt     = s_tdata[42:27];
    assign in_pid    = s_tdata[66:43];
    assign in_mid    = s_tdata[90:67];
    assign in_ceta   = s_tdata[104:91];
    assign in_iso[0] = s_tdata[120:105];
    assign in_iso[1] = s_tdata[136:121];
    assign in_iso[2] = s_tdata[152:137];
    assign in_rho    = s_tdata[164:153];

    assign in_abs_ceta = in_ceta[tmdr_pkg::ETA_W-1] ? tmdr_pkg::ETA_W'(-in_ceta)
                                                    : tmdr_pkg::ETA_W'(in_ceta);

    always_comb begin
        if (in_pid == tmdr_pkg::PHOTON_ID && in_mid >= tmdr_pkg::NEG_PHOTON_ID &&
            in_mid <= tmdr_pkg::PHOTON_ID) begin
            in_cls = tmdr_pkg::CLS_PHOTON;
        end else if ((in_pid == tmdr_pkg::ELECTRON_ID || in_pid == tmdr_pkg::POSITRON_ID)
                     && in_mid == tmdr_pkg::Z_ID) begin
            in_cls = tmdr_pkg::CLS_ELECTRON;
        end else begin
            in_cls = tmdr_pkg::CLS_OTHER;
        end
    end

    assign wr_entry = '{cls: in_cls, pt: in_pt, phi: in_phi, eta: in_eta};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign mem_we   = accept && in_op == tmdr_pkg::OP_APPEND && cnt_reg < DEPTH_C;
    assign issue    = (state_reg == ST_SCAN) && (iss_reg < cnt_reg);
    assign load_out = (state_reg == ST_FINISH) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        iss_next      = iss_reg;
        prep_next     = prep_reg;
        m_tvalid_next = m_tvalid_reg;
        dr_max_next   = dr_max_reg;
        frac_next     = frac_reg;

        if (cfg_wr_en) begin
            case (cfg_index)
                tmdr_pkg::CFG_DR_MAX_SQ:    dr_max_next = cfg_wdata;
                tmdr_pkg::CFG_DPT_MAX_FRAC: frac_next   = cfg_wdata[tmdr_pkg::FRAC_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (in_op)
                        tmdr_pkg::OP_CLEAR: cnt_next = '0;
                        tmdr_pkg::OP_APPEND: begin
                            if (mem_we) begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        tmdr_pkg::OP_QUERY: begin
                            state_next = ST_PREP;
                            prep_next  = 1'b0;
                            iss_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                prep_next = 1'b1;
                if (prep_reg) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    iss_next = iss_reg + 1'b1;
                end else if (!rd_vld_reg && !st2_vld_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (load_out) begin
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            iss_reg      <= '0;
            prep_reg     <= 1'b0;
            rd_vld_reg   <= 1'b0;
            st2_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            dr_max_reg   <= tmdr_pkg::DR_MAX_SQ_RST;
            frac_reg     <= tmdr_pkg::DPT_MAX_FRAC_RST;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            iss_reg      <= iss_next;
            prep_reg     <= prep_next;
            rd_vld_reg   <= issue;
            st2_vld_reg  <= rd_vld_reg;
            m_tvalid_reg <= m_tvalid_next;
            dr_max_reg   <= dr_max_next;
            frac_reg     <= frac_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[cnt_reg[AW-1:0]] <= wr_entry;
        end
        if (issue) begin
            mem_rdata_reg <= mem[iss_reg[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_op == tmdr_pkg::OP_QUERY) begin
            q_eta_reg <= in_eta;
            q_phi_reg <= in_phi;
            q_pt_reg  <= in_pt;
            q_bin_reg <= tmdr_pkg::area_bin(in_abs_ceta);
            q_rho_reg <= in_rho;
            q_iso_reg <= in_iso;
        end
    end

    tmdr_iso_corr u_iso_corr (
        .aclk (aclk),
        .bin  (q_bin_reg),
        .rho  (q_rho_reg),
        .iso  (q_iso_reg),
        .corr (iso_corr)
    );

    always_comb begin
        de     = {q_eta_reg[tmdr_pkg::ETA_W-1], q_eta_reg} -
                 {mem_rdata_reg.eta[tmdr_pkg::ETA_W-1], mem_rdata_reg.eta};
        dp_raw = {{2{q_phi_reg[tmdr_pkg::PHI_W-1]}}, q_phi_reg} -
                 {{2{mem_rdata_reg.phi[tmdr_pkg::PHI_W-1]}}, mem_rdata_reg.phi};
        dp_hi  = (dp_raw > tmdr_pkg::PI_FX) ? dp_raw - tmdr_pkg::TWO_PI_FX : dp_raw;
        dp     = (dp_hi < tmdr_pkg::NEG_PI_FX) ? dp_hi + tmdr_pkg::TWO_PI_FX : dp_hi;
        de_prod = de * de;
        dp_prod = dp * dp;
        pt_diff = (q_pt_reg >= mem_rdata_reg.pt) ? q_pt_reg - mem_rdata_reg.pt
                                                 : mem_rdata_reg.pt - q_pt_reg;
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            de_sq_reg  <= de_prod[tmdr_pkg::SQ_W-1:0];
            dp_sq_reg  <= dp_prod[tmdr_pkg::SQ_W-1:0];
            diff_reg   <= pt_diff;
            fracpt_reg <= 24'(frac_reg) * 24'(mem_rdata_reg.pt);
            t_reg      <= mem_rdata_reg;
        end
    end

    assign dr2 = {1'b0, de_sq_reg} + {1'b0, dp_sq_reg};
    assign hit = (dr2 < (tmdr_pkg::SQ_W + 1)'(dr_max_reg)) &&
                 ({diff_reg, 8'd0} < fracpt_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pm_reg <= 1'b0;
            em_reg <= 1'b0;
        end else if (accept && in_op == tmdr_pkg::OP_QUERY) begin
            pm_reg <= 1'b0;
            em_reg <= 1'b0;
        end else if (st2_vld_reg && hit) begin
            if (t_reg.cls == tmdr_pkg::CLS_PHOTON) begin
                pm_reg <= 1'b1;
            end else if (t_reg.cls == tmdr_pkg::CLS_ELECTRON) begin
                em_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && in_op == tmdr_pkg::OP_QUERY) begin
            mpt_reg  <= '0;
            meta_reg <= '0;
            mphi_reg <= '0;
        end else if (st2_vld_reg && hit && t_reg.cls == tmdr_pkg::CLS_PHOTON) begin
            mpt_reg  <= t_reg.pt;
            meta_reg <= t_reg.eta;
            mphi_reg <= t_reg.phi;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {iso_corr[2], iso_corr[1], iso_corr[0], q_bin_reg,
                            mphi_reg, meta_reg, mpt_reg, em_reg, pm_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `TMDR_ASSERT_IMPL(a_cnt_bound, aclk, aresetn, 1'b1, cnt_reg <= DEPTH_C)
    `TMDR_ASSERT_IMPL(a_finish_drained, aclk, aresetn, state_reg == ST_FINISH, !rd_vld_reg && !st2_vld_reg && iss_reg == cnt_reg)
    `TMDR_ASSERT_IMPL(a_out_from_finish, aclk, aresetn, m_tvalid_reg && !$past(m_tvalid_reg), $past(state_reg == ST_FINISH))
    `TMDR_ASSERT_NEXT(a_read_in_scan, aclk, aresetn, rd_vld_reg, state_reg == ST_SCAN || state_reg == ST_FINISH)

endmodule
